// ===== rtl/layer_overhang_support_check_defines.svh =====
`ifndef LAYER_OVERHANG_SUPPORT_CHECK_DEFINES_SVH
`define LAYER_OVERHANG_SUPPORT_CHECK_DEFINES_SVH

// Clocked check, switched off while reset is held
`define LOHS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also covers the reset cycles
`define LOHS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lohs_pkg.sv =====
package lohs_pkg;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int REG_W = 11;
  localparam int REG_IDX_BIT = 2;
  localparam logic [0:0] REG_COLUMN_COUNT = 1'b0;
  localparam logic [0:0] REG_ROW_COUNT = 1'b1;
  localparam logic [REG_W-1:0] REG_RESET = 11'd1024;
  localparam logic [REG_W-1:0] COUNT_MIN = 11'd3;

  // Item kinds and pixel classes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;
  localparam logic [1:0] CLS_SAME = 2'd0;
  localparam logic [1:0] CLS_LOWER = 2'd1;
  localparam logic [1:0] CLS_UPPER = 2'd2;

  // Reference rows rotate through three line slots
  localparam logic [1:0] SLOT_FIRST = 2'd0;
  localparam logic [1:0] SLOT_LAST = 2'd2;

  localparam int POS_W = 10;

  typedef struct packed {
    logic req_type;
    logic below_bit;
    logic above_bit;
    logic reference_bit;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_column;
    logic [1:0]       pixel_class;
    logic             needs_support;
    logic             last_pixel;
  } out_item_t;

  // Store write request
  typedef struct packed {
    logic       we;
    logic [2:0] line_sel;
    logic       ref_bit;
    logic       cslot;
    logic [1:0] cls;
  } wr_t;

  // Result stage control, captured when an item is taken
  typedef struct packed {
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             border;
    logic             last;
    logic [1:0]       slot;
    logic             cslot;
    logic [2:0]       line_hit;
    logic [2:0]       col_hit;
    logic             wr_bit;
    logic             cls_hit;
    logic [1:0]       wr_cls;
  } s1_t;

  // Registered store read data: three lines per word
  typedef struct packed {
    logic [2:0] ev_a;
    logic [2:0] ev_b;
    logic [2:0] od_a;
    logic [2:0] od_b;
    logic [3:0] cls_pair;
  } rd_t;

endpackage

// ===== rtl/lohs_cfg.sv =====
module lohs_cfg import lohs_pkg::*; #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS = 1024,
  localparam int CW = $clog2(MAX_COLUMNS),
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CCW = (CW + 1 > REG_W) ? CW + 1 : REG_W,
  localparam int RCW = (RW + 1 > REG_W) ? RW + 1 : REG_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [CCW-1:0]    used_cols,
  output logic [RCW-1:0]    used_rows
);

  logic [REG_W-1:0] column_count_r;
  logic [REG_W-1:0] row_count_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= REG_RESET;
      row_count_r <= REG_RESET;
    end else if (wr_en) begin
      unique case (paddr[REG_IDX_BIT])
        REG_COLUMN_COUNT: column_count_r <= pwdata[REG_W-1:0];
        REG_ROW_COUNT:    row_count_r <= pwdata[REG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_IDX_BIT])
      REG_COLUMN_COUNT: prdata = CFG_DW'(column_count_r);
      REG_ROW_COUNT:    prdata = CFG_DW'(row_count_r);
    endcase
  end

  // Clamp the counts to the range the buffers support
  always_comb begin
    priority if (column_count_r < COUNT_MIN) begin
      used_cols = CCW'(COUNT_MIN);
    end else if (CCW'(column_count_r) > CCW'(MAX_COLUMNS)) begin
      used_cols = CCW'(MAX_COLUMNS);
    end else begin
      used_cols = CCW'(column_count_r);
    end
  end

  always_comb begin
    priority if (row_count_r < COUNT_MIN) begin
      used_rows = RCW'(COUNT_MIN);
    end else if (RCW'(row_count_r) > RCW'(MAX_ROWS)) begin
      used_rows = RCW'(MAX_ROWS);
    end else begin
      used_rows = RCW'(row_count_r);
    end
  end

endmodule

// ===== rtl/lohs_ctrl.sv =====
module lohs_ctrl import lohs_pkg::*; #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS = 1024,
  localparam int CW = $clog2(MAX_COLUMNS),
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CCW = (CW + 1 > REG_W) ? CW + 1 : REG_W,
  localparam int RCW = (RW + 1 > REG_W) ? RW + 1 : REG_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  in_item_t       in_data,
  input  logic [CCW-1:0] used_cols,
  input  logic [RCW-1:0] used_rows,
  input  logic           adv,
  output wr_t            wr,
  output logic [CW-1:0]  wr_col,
  output logic [CW-1:0]  rd_col,
  output logic           s1_valid,
  output s1_t            s1
);

  logic [CW-1:0]  in_col_r, in_col_nxt;
  logic [1:0]     in_slot_r, in_slot_nxt;
  logic           in_cslot_r, in_cslot_nxt;
  logic [CW-1:0]  out_col_r, out_col_nxt;
  logic [RW-1:0]  out_row_r, out_row_nxt;
  logic [1:0]     out_slot_r, out_slot_nxt;
  logic           out_cslot_r, out_cslot_nxt;
  logic [CCW-1:0] pending_r, pending_nxt;
  logic           s1_valid_r, s1_valid_nxt;
  s1_t            s1_r, s1_nxt;

  logic           pix;
  logic           emit;
  logic           in_wrap;
  logic           col_end;
  logic           row_end;
  logic [1:0]     cls;
  logic [2:0]     line_sel;
  logic [CW-1:0]  col_m1;
  logic [CW-1:0]  col_p1;

  function automatic logic [1:0] slot_step(input logic [1:0] s);
    return (s == SLOT_LAST) ? SLOT_FIRST : s + 2'd1;
  endfunction

  assign pix = (in_data.req_type == REQ_PIXEL);

  always_comb begin
    unique case (in_data.req_type)
      REQ_PIXEL: emit = pending_r > used_cols;
      REQ_FLUSH: emit = pending_r != '0;
    endcase
  end

  always_comb begin
    if (in_data.below_bit == in_data.above_bit) begin
      cls = CLS_SAME;
    end else if (in_data.below_bit) begin
      cls = CLS_LOWER;
    end else begin
      cls = CLS_UPPER;
    end
  end

  assign in_wrap = (CCW'(in_col_r) + CCW'(1)) >= used_cols;
  assign col_end = (CCW'(out_col_r) + CCW'(1)) >= used_cols;
  assign row_end = (RCW'(out_row_r) + RCW'(1)) >= used_rows;

  assign line_sel = pix ? 3'(3'b001 << in_slot_r) : 3'b000;
  assign col_m1 = out_col_r - CW'(1);
  assign col_p1 = out_col_r + CW'(1);

  // Position, slot and pending count updates
  always_comb begin
    in_col_nxt = in_col_r;
    in_slot_nxt = in_slot_r;
    in_cslot_nxt = in_cslot_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    out_slot_nxt = out_slot_r;
    out_cslot_nxt = out_cslot_r;
    pending_nxt = pending_r;
    if (fire && pix) begin
      if (in_wrap) begin
        in_col_nxt = '0;
        in_slot_nxt = slot_step(in_slot_r);
        in_cslot_nxt = ~in_cslot_r;
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (!emit) begin
        pending_nxt = pending_r + CCW'(1);
      end
    end
    if (fire && !pix && emit) begin
      pending_nxt = pending_r - CCW'(1);
    end
    if (fire && emit) begin
      if (col_end) begin
        out_col_nxt = '0;
        out_slot_nxt = slot_step(out_slot_r);
        out_cslot_nxt = ~out_cslot_r;
        out_row_nxt = row_end ? '0 : out_row_r + RW'(1);
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
  end

  // Snapshot for the result stage; the hit flags forward this item's write
  always_comb begin
    s1_nxt.out_row = POS_W'(out_row_r);
    s1_nxt.out_col = POS_W'(out_col_r);
    s1_nxt.border = (out_row_r == '0) || row_end || (out_col_r == '0) || col_end;
    s1_nxt.last = row_end && col_end;
    s1_nxt.slot = out_slot_r;
    s1_nxt.cslot = out_cslot_r;
    s1_nxt.line_hit = line_sel;
    s1_nxt.col_hit = {in_col_r == col_p1, in_col_r == out_col_r, in_col_r == col_m1};
    s1_nxt.wr_bit = in_data.reference_bit;
    s1_nxt.cls_hit = pix && (in_cslot_r == out_cslot_r) && (in_col_r == out_col_r);
    s1_nxt.wr_cls = cls;
  end

  always_comb begin
    if (fire) begin
      s1_valid_nxt = emit;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_slot_r <= SLOT_FIRST;
      in_cslot_r <= 1'b0;
      out_col_r <= '0;
      out_row_r <= '0;
      out_slot_r <= SLOT_FIRST;
      out_cslot_r <= 1'b0;
      pending_r <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      in_col_r <= in_col_nxt;
      in_slot_r <= in_slot_nxt;
      in_cslot_r <= in_cslot_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      out_slot_r <= out_slot_nxt;
      out_cslot_r <= out_cslot_nxt;
      pending_r <= pending_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_r <= s1_nxt;
    end
  end

  assign wr.we = fire && pix;
  assign wr.line_sel = line_sel;
  assign wr.ref_bit = in_data.reference_bit;
  assign wr.cslot = in_cslot_r;
  assign wr.cls = cls;
  assign wr_col = in_col_r;
  assign rd_col = out_col_r;
  assign s1_valid = s1_valid_r;
  assign s1 = s1_r;

endmodule

// ===== rtl/lohs_store.sv =====
module lohs_store import lohs_pkg::*; #(
  parameter int MAX_COLUMNS = 1024,
  localparam int CW = $clog2(MAX_COLUMNS),
  localparam int AW = CW - 1,
  localparam int HALF = (MAX_COLUMNS + 1) / 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  wr_t           wr,
  input  logic [CW-1:0] wr_col,
  input  logic          rd_en,
  input  logic [CW-1:0] rd_col,
  output rd_t           rd,
  output logic          clearing
);

  // Reference lines split by column parity, one lane per line slot
  logic [2:0] ev_mem [HALF];
  logic [2:0] od_mem [HALF];
  // Class lines, one lane per class slot
  logic [3:0] cls_mem [MAX_COLUMNS];

  logic          clr_r;
  logic [CW-1:0] clr_addr_r;
  rd_t           rd_r;

  logic [CW-1:0] wa;
  logic [AW-1:0] ref_wa;
  logic [2:0]    ref_lanes;
  logic [2:0]    ev_we;
  logic [2:0]    od_we;
  logic          ref_din;
  logic [1:0]    cls_we;
  logic [1:0]    cls_din;
  logic [AW-1:0] h;
  logic [AW-1:0] hp;
  logic [AW-1:0] hm;

  // Sweep zeros through every entry after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + CW'(1);
      if (clr_addr_r == CW'(MAX_COLUMNS - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  assign wa = clr_r ? clr_addr_r : wr_col;
  assign ref_wa = wa[CW-1:1];
  assign ref_lanes = clr_r ? 3'b111 : (wr.we ? wr.line_sel : 3'b000);
  assign ev_we = wa[0] ? 3'b000 : ref_lanes;
  assign od_we = wa[0] ? ref_lanes : 3'b000;
  assign ref_din = clr_r ? 1'b0 : wr.ref_bit;
  assign cls_we = clr_r ? 2'b11 : (wr.we ? (wr.cslot ? 2'b10 : 2'b01) : 2'b00);
  assign cls_din = clr_r ? CLS_SAME : wr.cls;

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      if (ev_we[l]) begin
        ev_mem[ref_wa][l] <= ref_din;
      end
      if (od_we[l]) begin
        od_mem[ref_wa][l] <= ref_din;
      end
    end
    if (cls_we[0]) begin
      cls_mem[wa][1:0] <= cls_din;
    end
    if (cls_we[1]) begin
      cls_mem[wa][3:2] <= cls_din;
    end
  end

  // Columns c-1, c and c+1 fall in the two parity banks
  assign h = rd_col[CW-1:1];
  assign hp = h + AW'(1);
  assign hm = h - AW'(1);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r.ev_a <= ev_mem[h];
      rd_r.ev_b <= ev_mem[hp];
      rd_r.od_a <= od_mem[h];
      rd_r.od_b <= od_mem[hm];
      rd_r.cls_pair <= cls_mem[rd_col];
    end
  end

  assign rd = rd_r;
  assign clearing = clr_r;

endmodule

// ===== rtl/lohs_out.sv =====
module lohs_out import lohs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s1_valid,
  input  s1_t       s1,
  input  rd_t       rd,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data,
  output logic      adv
);

  logic            out_valid_r;
  out_item_t       out_data_r, out_data_nxt;
  logic [2:0][2:0] raw;
  logic [2:0][2:0] cells;
  logic [2:0]      slot_oh;
  logic            nbr_any;
  logic [1:0]      cls;

  assign adv = !out_valid_r || !out_stall;

  // Pick left, centre and right columns by parity of the column
  always_comb begin
    if (s1.out_col[0]) begin
      raw[0] = rd.ev_a;
      raw[1] = rd.od_a;
      raw[2] = rd.ev_b;
    end else begin
      raw[0] = rd.od_b;
      raw[1] = rd.ev_a;
      raw[2] = rd.od_a;
    end
  end

  always_comb begin
    for (int dc = 0; dc < 3; dc++) begin
      cells[dc] = (raw[dc] & ~(s1.line_hit & {3{s1.col_hit[dc]}}))
                | ({3{s1.wr_bit}} & s1.line_hit & {3{s1.col_hit[dc]}});
    end
  end

  // The pixel itself is not its own neighbour
  assign slot_oh = 3'(3'b001 << s1.slot);
  assign nbr_any = (|cells[0]) || (|cells[2]) || (|(cells[1] & ~slot_oh));

  always_comb begin
    if (s1.cls_hit) begin
      cls = s1.wr_cls;
    end else begin
      cls = s1.cslot ? rd.cls_pair[3:2] : rd.cls_pair[1:0];
    end
  end

  always_comb begin
    out_data_nxt.out_row = s1.out_row;
    out_data_nxt.out_column = s1.out_col;
    out_data_nxt.pixel_class = cls;
    out_data_nxt.needs_support = (cls == CLS_UPPER) && !s1.border && !nbr_any;
    out_data_nxt.last_pixel = s1.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

// ===== rtl/layer_overhang_support_check.sv =====
// A result is captured in the result stage when the item causing it is taken, then registered in the output stage.
// Throughput: one item per cycle while in_stall is low; each item does one window read, and each pixel
// item one write, of the parity-split line stores, with the same-cycle write forwarded into the window.
// Reset: synchronous; after reset the line stores are cleared through all MAX_COLUMNS entries with
// in_stall high; column_count and row_count reset to 1024 and take writes during clearing.
module layer_overhang_support_check import lohs_pkg::*; #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CCW = (CW + 1 > REG_W) ? CW + 1 : REG_W;
  localparam int RCW = (RW + 1 > REG_W) ? RW + 1 : REG_W;

  logic [CCW-1:0] used_cols;
  logic [RCW-1:0] used_rows;
  logic           fire;
  logic           clearing;
  logic           adv;
  logic           s1_valid;
  s1_t            s1;
  wr_t            wr;
  rd_t            rd;
  logic [CW-1:0]  wr_col;
  logic [CW-1:0]  rd_col;

  // Hold input while clearing or while a result is blocked in both stages
  assign in_stall = clearing || (s1_valid && !adv);
  assign fire = in_valid && !in_stall;

  lohs_cfg #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS(MAX_ROWS)
  ) u_cfg (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .used_cols(used_cols),
    .used_rows(used_rows)
  );

  lohs_ctrl #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS(MAX_ROWS)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .fire(fire),
    .in_data(in_data),
    .used_cols(used_cols),
    .used_rows(used_rows),
    .adv(adv),
    .wr(wr),
    .wr_col(wr_col),
    .rd_col(rd_col),
    .s1_valid(s1_valid),
    .s1(s1)
  );

  lohs_store #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_store (
    .clk(clk),
    .rst_n(rst_n),
    .wr(wr),
    .wr_col(wr_col),
    .rd_en(fire),
    .rd_col(rd_col),
    .rd(rd),
    .clearing(clearing)
  );

  lohs_out u_out (
    .clk(clk),
    .rst_n(rst_n),
    .s1_valid(s1_valid),
    .s1(s1),
    .rd(rd),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data(out_data),
    .adv(adv)
  );

endmodule

// ===== rtl/lohs_chk.sv =====
`include "layer_overhang_support_check_defines.svh"

module lohs_chk import lohs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input out_item_t         out_data,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [CFG_AW-1:0] paddr,
  input logic [CFG_DW-1:0] pwdata,
  input logic [CFG_DW-1:0] prdata
);

  // Stalled result holds
  `LOHS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed while stalled")

  // Support is only flagged for an overhang that is not the last pixel
  `LOHS_ASSERT(a_support_class, out_valid && out_data.needs_support |-> out_data.pixel_class == CLS_UPPER && !out_data.last_pixel, "support flag on a non-overhang or border pixel")

  // Register write is visible on the next read of the same address
  `LOHS_ASSERT(a_cfg_readback, psel && penable && pwrite |=> (paddr != $past(paddr)) || (prdata[REG_W-1:0] == $past(pwdata[REG_W-1:0])), "register readback mismatch")

  // Out of reset: no result, input held for the clearing sweep
  `LOHS_ASSERT_RST(a_reset_quiet, !rst_n |=> in_stall && !out_valid, "block not quiet after reset")

endmodule

bind layer_overhang_support_check lohs_chk u_chk (.*);
